@@ src/sbet_pkg.sv @@
// ----------------------------------------------------------------------------
// sbet_pkg
// Shared constants for the swept box entry time block.
// ----------------------------------------------------------------------------
package sbet_pkg;

  // Default coordinate width, signed fixed point
  localparam int unsigned COORD_BITS = 32;
  // Default number of fraction bits in coordinates and times
  localparam int unsigned FRAC_BITS  = 16;

endpackage

@@ src/sbet_div.sv @@
// ----------------------------------------------------------------------------
// sbet_div
// Pipelined signed fixed-point divider: floor(num * 2^FB / den), saturated
// to [-2.0, 2.0]. One quotient bit per stage.
// ----------------------------------------------------------------------------
module sbet_div #(
  parameter int unsigned CB = sbet_pkg::COORD_BITS,
  parameter int unsigned FB = sbet_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic signed [CB+1:0] num,
  input  logic signed [CB-1:0] den,
  output logic signed [FB+2:0] quo,
  output logic                 den_zero
);

  localparam int unsigned DW = CB + 2;
  localparam int unsigned TW = FB + 3;
  localparam logic signed [TW-1:0] TWO     = TW'(64'd2 << FB);
  localparam logic signed [TW-1:0] NEG_TWO = TW'(0) - TWO;

  // Stage 1: magnitudes and sign
  logic [DW-1:0] a1;
  logic [CB-1:0] b1;
  logic          neg1, zero1;

  always_ff @(posedge clk) begin
    a1    <= num[DW-1] ? DW'(0) - num : num;
    b1    <= den[CB-1] ? CB'(0) - den : den;
    neg1  <= (num != '0) && (num[DW-1] != den[CB-1]);
    zero1 <= (den == '0);
  end

  // Stage 2: saturation check and integer quotient bit
  logic [CB-1:0] r_st [FB+1];
  logic [FB:0]   q_st [FB+1];
  logic [CB-1:0] b_st [FB+1];
  logic          neg_st [FB+1];
  logic          sat_st [FB+1];
  logic          zero_st [FB+1];

  logic [DW-1:0] b1_ext;
  logic [DW-1:0] b1_dbl;
  logic          int_bit;

  assign b1_ext  = DW'(b1);
  assign b1_dbl  = DW'({b1, 1'b0});
  assign int_bit = (a1 >= b1_ext);

  always_ff @(posedge clk) begin
    sat_st[0]  <= (a1 >= b1_dbl);
    r_st[0]    <= CB'(a1 - (int_bit ? b1_ext : DW'(0)));
    q_st[0]    <= (FB+1)'(int_bit);
    b_st[0]    <= b1;
    neg_st[0]  <= neg1;
    zero_st[0] <= zero1;
  end

  // Fraction bits, one restoring step per stage
  for (genvar i = 0; i < FB; i++) begin : g_step
    logic [CB:0] r2;
    logic [CB:0] bx;
    logic        ge;

    assign r2 = {r_st[i], 1'b0};
    assign bx = {1'b0, b_st[i]};
    assign ge = (r2 >= bx);

    always_ff @(posedge clk) begin
      r_st[i+1]    <= ge ? CB'(r2 - bx) : CB'(r2);
      q_st[i+1]    <= {q_st[i][FB-1:0], ge};
      b_st[i+1]    <= b_st[i];
      neg_st[i+1]  <= neg_st[i];
      sat_st[i+1]  <= sat_st[i];
      zero_st[i+1] <= zero_st[i];
    end
  end

  // Final stage: sign, floor correction, saturation
  logic [TW-1:0] q_mag;

  assign q_mag = TW'(q_st[FB]) + TW'(r_st[FB] != '0);

  always_ff @(posedge clk) begin
    if (sat_st[FB]) begin
      quo <= neg_st[FB] ? NEG_TWO : TWO;
    end else if (neg_st[FB]) begin
      quo <= TW'(0) - q_mag;
    end else begin
      quo <= TW'(q_st[FB]);
    end
    den_zero <= zero_st[FB];
  end

endmodule

@@ src/swept_box_entry_time.sv @@
// ----------------------------------------------------------------------------
// swept_box_entry_time
// Swept 2D box test: entry time of a moving box against a fixed box.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the ten box fields and pulse start; a transaction is taken at a
//   rising edge where start is high and busy is low. busy is high only while
//   rst is high, so one transaction can enter in every cycle.
//   Each transaction yields exactly one result: entry_time and hit are valid
//   for the single cycle in which done is high. Results leave in order.
//   A transaction passes the capture, distance, divider and final registers
//   in order; throughput is one per cycle. The pipeline depth is set mostly
//   by the four pipelined dividers, which resolve one quotient bit per stage
//   (FRAC_BITS + 1 bits, plus setup and rounding).
//   The receiver cannot stall: results are presented once and never held.
//   Reset clears the valid chain, so no result is produced for transactions
//   still in flight; payload registers are not reset.
//   entry_time is Q.16 in 0..1.0; when hit is low it reads exactly 1.0.
// ----------------------------------------------------------------------------
module swept_box_entry_time #(
  parameter int unsigned COORD_BITS = sbet_pkg::COORD_BITS,
  parameter int unsigned FRAC_BITS  = sbet_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] mover_x,
  input  logic signed [COORD_BITS-1:0] mover_y,
  input  logic        [COORD_BITS-2:0] mover_width,
  input  logic        [COORD_BITS-2:0] mover_height,
  input  logic signed [COORD_BITS-1:0] velocity_x,
  input  logic signed [COORD_BITS-1:0] velocity_y,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  input  logic        [COORD_BITS-2:0] target_width,
  input  logic        [COORD_BITS-2:0] target_height,
  output logic                         done,
  output logic        [FRAC_BITS:0]    entry_time,
  output logic                         hit
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DW  = CB + 2;
  localparam int unsigned TW  = FRAC_BITS + 3;
  localparam int unsigned LAT = FRAC_BITS + 6;
  localparam logic signed [TW-1:0] ONE     = TW'(64'd1 << FRAC_BITS);
  localparam logic signed [TW-1:0] TWO     = TW'(64'd2 << FRAC_BITS);
  localparam logic signed [TW-1:0] NEG_TWO = TW'(0) - TWO;

  logic accept;

  // Hold off only during reset
  assign busy   = rst;
  assign accept = start && !busy;

  // Valid chain, one bit per pipeline register stage
  logic [LAT-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-2:0], accept};
    end
  end

  assign done = valid[LAT-1];

  // Stage 1: capture the transaction
  logic signed [CB-1:0] mx, my, vx, vy, tx, ty;
  logic        [CB-2:0] mw, mh, tw, th;

  always_ff @(posedge clk) begin
    mx <= mover_x;
    my <= mover_y;
    mw <= mover_width;
    mh <= mover_height;
    vx <= velocity_x;
    vy <= velocity_y;
    tx <= target_x;
    ty <= target_y;
    tw <= target_width;
    th <= target_height;
  end

  // Stage 2: entry and exit distances, picked by velocity sign
  logic signed [DW-1:0] near_x, far_x, near_y, far_y;
  logic signed [DW-1:0] xe_d, xx_d, ye_d, yx_d;
  logic signed [CB-1:0] vx2, vy2;

  // near: gap from mover's far edge to target's low edge
  // far:  span from mover's low edge to target's high edge
  assign near_x = DW'(tx) - DW'(mx) - $signed(DW'(mw));
  assign far_x  = DW'(tx) + $signed(DW'(tw)) - DW'(mx);
  assign near_y = DW'(ty) - DW'(my) - $signed(DW'(mh));
  assign far_y  = DW'(ty) + $signed(DW'(th)) - DW'(my);

  always_ff @(posedge clk) begin
    if (vx > 0) begin
      xe_d <= near_x;
      xx_d <= far_x;
    end else begin
      xe_d <= far_x;
      xx_d <= near_x;
    end
    if (vy > 0) begin
      ye_d <= near_y;
      yx_d <= far_y;
    end else begin
      ye_d <= far_y;
      yx_d <= near_y;
    end
    vx2 <= vx;
    vy2 <= vy;
  end

  // Dividers: distance over velocity, one per time value
  logic signed [TW-1:0] xe_q, xx_q, ye_q, yx_q;
  logic                 xe_z, xx_z, ye_z, yx_z;

  sbet_div #(.CB(CB), .FB(FRAC_BITS)) u_div_xe (
    .clk(clk), .num(xe_d), .den(vx2), .quo(xe_q), .den_zero(xe_z)
  );
  sbet_div #(.CB(CB), .FB(FRAC_BITS)) u_div_xx (
    .clk(clk), .num(xx_d), .den(vx2), .quo(xx_q), .den_zero(xx_z)
  );
  sbet_div #(.CB(CB), .FB(FRAC_BITS)) u_div_ye (
    .clk(clk), .num(ye_d), .den(vy2), .quo(ye_q), .den_zero(ye_z)
  );
  sbet_div #(.CB(CB), .FB(FRAC_BITS)) u_div_yx (
    .clk(clk), .num(yx_d), .den(vy2), .quo(yx_q), .den_zero(yx_z)
  );

  // Final stage: a still axis spans the widest interval
  logic signed [TW-1:0] xe, xx, ye, yx, t_in, t_out;
  logic                 miss;

  assign xe    = xe_z ? NEG_TWO : xe_q;
  assign xx    = xx_z ? TWO     : xx_q;
  assign ye    = ye_z ? NEG_TWO : ye_q;
  assign yx    = yx_z ? TWO     : yx_q;
  assign t_in  = (xe > ye) ? xe : ye;
  assign t_out = (xx < yx) ? xx : yx;
  assign miss  = (t_in > t_out) || (xe < 0 && ye < 0) || (xe > ONE) || (ye > ONE);

  always_ff @(posedge clk) begin
    entry_time <= miss ? ONE[FRAC_BITS:0] : t_in[FRAC_BITS:0];
    hit        <= !miss;
  end

`ifndef SYNTHESIS
  localparam logic [FRAC_BITS:0] ONE_OUT = ONE[FRAC_BITS:0];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("result missing after fixed latency");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_time <= ONE_OUT)
    else $error("entry time beyond one step");

  a_miss_time: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> entry_time == ONE_OUT)
    else $error("miss without full step time");
`endif

endmodule

@@ bench/swept_box_entry_time_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_entry_time_checker
// Watches the box transactions and the result strobe, predicts entry time
// and hit for every accepted box pair, and counts mismatches.
// ----------------------------------------------------------------------------
module swept_box_entry_time_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] mover_x,
  input  logic [31:0] mover_y,
  input  logic [30:0] mover_width,
  input  logic [30:0] mover_height,
  input  logic [31:0] velocity_x,
  input  logic [31:0] velocity_y,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [30:0] target_width,
  input  logic [30:0] target_height,
  input  logic        done,
  input  logic [16:0] entry_time,
  input  logic        hit,
  output int          fail_count,
  output int          pending
);

  localparam int FRAC = sbet_pkg::FRAC_BITS;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint TWO_Q = longint'(2) << FRAC;

  typedef struct packed {
    logic [16:0] entry_time;
    logic        hit;
  } contact_t;

  contact_t contact_q[$];

  // Floor of num * 2^FRAC / den, saturated to +/-2.0.
  function automatic longint time_quotient(longint num, longint den);
    bit     neg;
    longint a, b, q, r;
    neg = (num != 0) && ((num < 0) != (den < 0));
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    if (a >= 2 * b) return neg ? -TWO_Q : TWO_Q;
    q = a / b;
    r = a % b;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 1;
      end
    end
    if (!neg) return q;
    return -(q + ((r != 0) ? 1 : 0));
  endfunction

  function automatic void axis_window(input longint lo, input longint size,
                                      input longint vel,
                                      input longint t_lo, input longint t_size,
                                      output longint t_in, output longint t_out);
    longint d_in, d_out;
    if (vel > 0) begin
      d_in  = t_lo - (lo + size);
      d_out = (t_lo + t_size) - lo;
    end else begin
      d_in  = (t_lo + t_size) - lo;
      d_out = t_lo - (lo + size);
    end
    if (vel == 0) begin
      t_in  = -TWO_Q;
      t_out = TWO_Q;
    end else begin
      t_in  = time_quotient(d_in, vel);
      t_out = time_quotient(d_out, vel);
    end
  endfunction

  function automatic contact_t predict_contact();
    longint   xi, xo, yi, yo, t_in, t_out;
    contact_t c;
    axis_window(longint'($signed(mover_x)), longint'(mover_width),
                longint'($signed(velocity_x)), longint'($signed(target_x)),
                longint'(target_width), xi, xo);
    axis_window(longint'($signed(mover_y)), longint'(mover_height),
                longint'($signed(velocity_y)), longint'($signed(target_y)),
                longint'(target_height), yi, yo);
    t_in  = (xi > yi) ? xi : yi;
    t_out = (xo < yo) ? xo : yo;
    if ((t_in > t_out) || (xi < 0 && yi < 0) || (xi > ONE_Q) || (yi > ONE_Q)) begin
      c.entry_time = 17'(ONE_Q);
      c.hit = 1'b0;
    end else begin
      c.entry_time = 17'(t_in);
      c.hit = 1'b1;
    end
    return c;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    contact_t want;
    int       errs;
    errs = 0;
    // Retire the result first, then queue the new transaction's prediction.
    if (!rst && done) begin
      if (contact_q.size() == 0) begin
        $display("%0t: result with nothing expected: entry_time %0d hit %0b",
                 $time, entry_time, hit);
        errs++;
      end else begin
        want = contact_q.pop_front();
        if (want.entry_time !== entry_time) begin
          $display("%0t: entry_time expected %0d actual %0d",
                   $time, want.entry_time, entry_time);
          errs++;
        end
        if (want.hit !== hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          errs++;
        end
      end
    end
    if (!rst && start && !busy) contact_q.push_back(predict_contact());
    if (errs != 0) fail_count <= fail_count + errs;
    pending <= contact_q.size();
  end

endmodule

@@ bench/swept_box_entry_time_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_entry_time_test
// Drives directed and random box pairs into the swept box block with random
// gaps; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module swept_box_entry_time_test;

  localparam int RANDOM_PAIRS = 600;
  localparam int SETTLE       = 40;      // longer than the block's pipeline latency
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] mover_x, mover_y, velocity_x, velocity_y, target_x, target_y;
  logic [30:0] mover_width, mover_height, target_width, target_height;
  logic        done;
  logic [16:0] entry_time;
  logic        hit;
  int          fail_count;
  int          pending;
  int          cycle_count;

  swept_box_entry_time uut (
    .clk, .rst, .start, .busy,
    .mover_x, .mover_y, .mover_width, .mover_height,
    .velocity_x, .velocity_y, .target_x, .target_y,
    .target_width, .target_height,
    .done, .entry_time, .hit
  );

  swept_box_entry_time_checker checker_i (
    .clk, .rst, .start, .busy,
    .mover_x, .mover_y, .mover_width, .mover_height,
    .velocity_x, .velocity_y, .target_x, .target_y,
    .target_width, .target_height,
    .done, .entry_time, .hit,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Hold one box pair on the ports until the block takes it. Idle gaps come
  // before raising start, so start never drops and rises in the same step.
  task automatic send_pair(input logic [31:0] mx, my, input logic [30:0] mw, mh,
                           input logic [31:0] vx, vy, tx, ty,
                           input logic [30:0] tw, th, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    mover_x       <= mx;
    mover_y       <= my;
    mover_width   <= mw;
    mover_height  <= mh;
    velocity_x    <= vx;
    velocity_y    <= vy;
    target_x      <= tx;
    target_y      <= ty;
    target_width  <= tw;
    target_height <= th;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Small coordinate in Q16.16: a few units either way, random fraction.
  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(16 << 16)) - (8 << 16));
  endfunction

  // Random box field: mostly small values, sometimes full-width noise.
  function automatic logic [31:0] any_word(input bit wide);
    return wide ? $urandom() : near_coord();
  endfunction

  initial begin
    logic [31:0] mx, my, vx, vy, tx, ty;
    logic [30:0] mw, mh, tw, th;
    bit          wide;
    rst = 1'b1;
    start = 1'b0;
    {mover_x, mover_y, velocity_x, velocity_y, target_x, target_y} = '0;
    {mover_width, mover_height, target_width, target_height} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: head-on hit along x, stationary overlap, zero velocity miss,
    // negative velocity, grazing contact at t = 1.0, and the field extremes.
    send_pair(0, 0, 31'h1_0000, 31'h1_0000, 32'h4_0000, 0,
              32'h2_0000, 0, 31'h1_0000, 31'h1_0000, 0);
    send_pair(0, 0, 31'h1_0000, 31'h1_0000, 0, 0,
              32'h8000, 32'h8000, 31'h1_0000, 31'h1_0000, 0);
    send_pair(0, 0, 31'h1_0000, 31'h1_0000, 0, 0,
              32'h5_0000, 0, 31'h1_0000, 31'h1_0000, 0);
    send_pair(32'h4_0000, 0, 31'h1_0000, 31'h1_0000, 32'hFFFC_0000, 0,
              0, 0, 31'h1_0000, 31'h1_0000, 0);
    send_pair(0, 0, 31'h1_0000, 31'h1_0000, 32'h1_0000, 0,
              32'h2_0000, 0, 31'h1_0000, 31'h1_0000, 0);
    send_pair(0, 0, 31'h1_0000, 31'h1_0000, 32'h3, 32'hFFFF_FFFD,
              32'h1_0000, 32'hFFFF_0000, 31'h1_0000, 31'h1_0000, 0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, 32'h1, 32'hFFFF_FFFF,
              0, 0, 0, 31'h7FFF_FFFF, 0);
    // Both axes moving, entry later on y than x.
    send_pair(0, 0, 31'h1_0000, 31'h1_0000, 32'h4_0000, 32'h4_0000,
              32'h2_0000, 32'h3_0000, 31'h2_0000, 31'h2_0000, 0);
    // Already past the target: both entries negative.
    send_pair(32'h3_0000, 32'h3_0000, 31'h1_0000, 31'h1_0000, 32'h1_0000, 32'h1_0000,
              0, 0, 31'h1_0000, 31'h1_0000, 0);
    start <= 1'b0;

    // Drain fully before the random part.
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random: about a fifth full-width noise; the rest near-range pairs that
    // tend to hit. The middle stretch sends back to back with no gaps.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      wide = ($urandom_range(99) < 20);
      mx = any_word(wide);
      my = any_word(wide);
      vx = ($urandom_range(9) == 0) ? 32'h0 : any_word(wide);
      vy = ($urandom_range(9) == 0) ? 32'h0 : any_word(wide);
      tx = any_word(wide);
      ty = any_word(wide);
      mw = wide ? 31'($urandom()) : 31'($urandom_range(3 << 16));
      mh = wide ? 31'($urandom()) : 31'($urandom_range(3 << 16));
      tw = wide ? 31'($urandom()) : 31'($urandom_range(3 << 16));
      th = wide ? 31'($urandom()) : 31'($urandom_range(3 << 16));
      send_pair(mx, my, mw, mh, vx, vy, tx, ty, tw, th, !(n >= 200 && n < 300));
      if (n == 400) begin
        // Pause until the pipeline is empty, then resume.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
